>>> sv/htfd_pkg.sv
// Package for the humidity/temperature frame decoder.
// Holds the status codes, the CRC and scaling constants, the frame record and the CRC function.
// No dependencies; every other file of the block but htfd_if refers to it by scoped names.
package htfd_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_VALID   = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_CRC_ERR = 2'd2
    } status_t;

    localparam logic [7:0]  CRC_INIT       = 8'hFF;
    localparam logic [7:0]  CRC_POLY       = 8'h31;
    localparam logic [2:0]  FIRST_POS      = 3'd0;
    localparam logic [2:0]  LAST_POS       = 3'd6;
    localparam logic [6:0]  HUM_SCALE      = 7'd100;
    localparam logic [7:0]  TEMP_SCALE     = 8'd200;
    localparam logic [16:0] TEMP_OFFSET_Q8 = 17'd12800;
    localparam int          FRAC_SHIFT     = 12;

    // One complete frame as handed from the front end to the back end.
    typedef struct packed {
        status_t     status;
        logic [19:0] humidity_raw;
        logic [19:0] temperature_raw;
        logic [7:0]  crc;
    } frame_t;

    // Handshake of the frame queue.
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } frame_push_t;

    // CRC-8 update over one byte, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (crc[7])
            begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

>>> sv/htfd_if.sv
// Channel interfaces of the frame decoder: the byte input and the result output.
// Depends on nothing; the payload widths are fixed by the frame format.
interface htfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_status;
    logic [19:0]        humidity_raw;
    logic [19:0]        temperature_raw;
    logic [14:0]        humidity_percent_q8;
    logic signed [16:0] temperature_c_q8;
    logic [7:0]         computed_crc;

    modport source (output valid, output result_status, output humidity_raw,
                    output temperature_raw, output humidity_percent_q8,
                    output temperature_c_q8, output computed_crc, input ready);
    modport sink (input valid, input result_status, input humidity_raw,
                  input temperature_raw, input humidity_percent_q8,
                  input temperature_c_q8, input computed_crc, output ready);
endinterface

>>> sv/htfd_front.sv
// Front end: tracks the frame position, runs the CRC and collects the payload bytes.
// Depends on htfd_pkg and htfd_byte_if; pushes one frame record per completed frame.
module htfd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    htfd_byte_if.sink            byte_in,
    input  logic                 push_ready,
    output htfd_pkg::frame_push_t push
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        busy_reg, busy_next;
    logic [39:0] payload_reg, payload_next;

    logic [2:0]  eff_pos;
    logic [7:0]  crc_step;
    logic        accept;
    logic        at_last;

    // A frame start forces the word to be taken as byte 0.
    assign eff_pos  = byte_in.frame_start ? htfd_pkg::FIRST_POS : pos_reg;
    assign at_last  = (eff_pos >= htfd_pkg::LAST_POS);
    assign crc_step = htfd_pkg::crc8_byte(
        (eff_pos == htfd_pkg::FIRST_POS) ? htfd_pkg::CRC_INIT : crc_reg, byte_in.rx_byte);

    // Only the closing byte needs room in the queue.
    assign byte_in.ready = push_ready || !at_last;
    assign accept        = byte_in.valid && byte_in.ready;

    // Frame record built from the stored state and the CRC byte.
    always_comb
    begin
        push.valid                 = accept && at_last;
        push.frame.humidity_raw    = payload_reg[39:20];
        push.frame.temperature_raw = payload_reg[19:0];
        push.frame.crc             = crc_reg;
        if (busy_reg)
        begin
            push.frame.status = htfd_pkg::STATUS_BUSY;
        end
        else if (crc_reg != byte_in.rx_byte)
        begin
            push.frame.status = htfd_pkg::STATUS_CRC_ERR;
        end
        else
        begin
            push.frame.status = htfd_pkg::STATUS_VALID;
        end
    end

    // Next state of the frame tracker.
    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        busy_next    = busy_reg;
        payload_next = payload_reg;
        if (accept)
        begin
            if (eff_pos == htfd_pkg::FIRST_POS)
            begin
                crc_next     = crc_step;
                busy_next    = byte_in.rx_byte[7];
                payload_next = '0;
                pos_next     = 3'd1;
            end
            else if (!at_last)
            begin
                crc_next     = crc_step;
                payload_next = {payload_reg[31:0], byte_in.rx_byte};
                pos_next     = eff_pos + 3'd1;
            end
            else
            begin
                crc_next = htfd_pkg::CRC_INIT;
                pos_next = htfd_pkg::FIRST_POS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= htfd_pkg::FIRST_POS;
            crc_reg     <= htfd_pkg::CRC_INIT;
            busy_reg    <= 1'b0;
            payload_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            busy_reg    <= busy_next;
            payload_reg <= payload_next;
        end
    end

endmodule

>>> sv/htfd_queue.sv
// Short queue of frame records between the front end and the back end.
// Depends on htfd_pkg for the frame record type.
module htfd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  htfd_pkg::frame_push_t push,
    output logic                  push_ready,
    output logic                  pop_valid,
    output htfd_pkg::frame_t      pop_frame,
    input  logic                  pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    htfd_pkg::frame_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_frame  = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Frame storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.frame;
        end
    end

endmodule

>>> sv/htfd_back.sv
// Back end: scales the raw readings to Q8 units and holds the result in an output register.
// Depends on htfd_pkg and htfd_result_if.
module htfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  htfd_pkg::frame_t pop_frame,
    output logic             pop_ready,
    htfd_result_if.source    result_out
);

    localparam int HUM_PROD_W  = 27;
    localparam int TEMP_PROD_W = 28;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             status_reg;
    logic [19:0]            hum_raw_reg;
    logic [19:0]            temp_raw_reg;
    logic [14:0]            hum_q8_reg;
    logic signed [16:0]     temp_q8_reg;
    logic [7:0]             crc_reg;

    logic [HUM_PROD_W-1:0]  hum_prod;
    logic [TEMP_PROD_W-1:0] temp_prod;
    logic [15:0]            temp_scaled;
    logic [16:0]            temp_q8;
    logic                   load;

    // Constant-coefficient scaling; the shift keeps the integer part in Q8.
    assign hum_prod    = HUM_PROD_W'(pop_frame.humidity_raw) * HUM_PROD_W'(htfd_pkg::HUM_SCALE);
    assign temp_prod   = TEMP_PROD_W'(pop_frame.temperature_raw)
                         * TEMP_PROD_W'(htfd_pkg::TEMP_SCALE);
    assign temp_scaled = temp_prod[TEMP_PROD_W-1:htfd_pkg::FRAC_SHIFT];
    assign temp_q8     = {1'b0, temp_scaled} - htfd_pkg::TEMP_OFFSET_Q8;

    // The output register takes a new word when empty or being drained.
    assign pop_ready = !out_valid_reg || result_out.ready;
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop_ready)
        begin
            out_valid_next = pop_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg   <= pop_frame.status;
            hum_raw_reg  <= pop_frame.humidity_raw;
            temp_raw_reg <= pop_frame.temperature_raw;
            hum_q8_reg   <= hum_prod[HUM_PROD_W-1:htfd_pkg::FRAC_SHIFT];
            temp_q8_reg  <= signed'(temp_q8);
            crc_reg      <= pop_frame.crc;
        end
    end

    assign result_out.valid               = out_valid_reg;
    assign result_out.result_status       = status_reg;
    assign result_out.humidity_raw        = hum_raw_reg;
    assign result_out.temperature_raw     = temp_raw_reg;
    assign result_out.humidity_percent_q8 = hum_q8_reg;
    assign result_out.temperature_c_q8    = temp_q8_reg;
    assign result_out.computed_crc        = crc_reg;

endmodule

>>> sv/humidity_temp_frame_decoder_top.sv
// Top level of the humidity/temperature reply frame decoder.
// Depends on htfd_pkg, htfd_if, htfd_front, htfd_queue and htfd_back.
//
//   Channel     Direction  Word
//   byte_in     in         rx_byte, frame_start: one reply byte
//   result_out  out        status, raw readings, Q8 readings, CRC: one per frame
//
// One byte is taken per cycle, but a closing byte waits while the frame queue is full. A
// result passes a queue slot and the output register. The CRC update of each byte is
// combinational, and the scaling is one constant multiply per reading in the back end.
// Reset returns the frame position to byte 0 and the CRC to its seed. A stalled result only
// holds back the input once the frame queue is full, and then only closing bytes wait.
module humidity_temp_frame_decoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    htfd_byte_if.sink      byte_in,
    htfd_result_if.source  result_out
);

    htfd_pkg::frame_push_t push;
    logic                  push_ready;
    logic                  pop_valid;
    htfd_pkg::frame_t      pop_frame;
    logic                  pop_ready;

    htfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .push_ready (push_ready),
        .push       (push)
    );

    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_frame  (pop_frame),
        .pop_ready  (pop_ready)
    );

    htfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_frame  (pop_frame),
        .pop_ready  (pop_ready),
        .result_out (result_out)
    );

endmodule

>>> tb/humidity_temp_frame_decoder_top_tb.sv
// Self-checking testbench for the humidity/temperature reply frame decoder.
// Depends on htfd_pkg, htfd_if and humidity_temp_frame_decoder_top; predicts every result
// from the accepted bytes, or types some directed fields in, and checks each result field.
module humidity_temp_frame_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  CRC_SEED      = 8'hFF;
    localparam logic [7:0]  CRC8_POLY     = 8'h31;
    localparam logic [2:0]  FRAME_LAST    = 3'd6;
    localparam logic [16:0] ZERO_C_OFFSET = 17'd12800;
    localparam int          RANDOM_ITEMS  = 1600;
    localparam int          HOLD_FIRST    = 20;
    localparam int          HOLD_SECOND   = 140;
    localparam int          LONG_HOLD     = 400;
    localparam int          TAIL_CYCLES   = 10;
    localparam int          TIMEOUT_NS    = 400_000;

    // How the closing byte of a directed frame is formed.
    typedef enum logic [1:0] {
        BYTE_AS_IS    = 2'd0,
        BYTE_CRC_GOOD = 2'd1,
        BYTE_CRC_BAD  = 2'd2
    } close_t;

    // Which fields of a directed result are typed in rather than predicted.
    typedef enum logic [1:0] {
        PIN_NONE   = 2'd0,
        PIN_STATUS = 2'd1,
        PIN_ALL    = 2'd2
    } pin_t;

    typedef struct packed {
        htfd_pkg::status_t status;
        logic [19:0]       hum_raw;
        logic [19:0]       temp_raw;
        logic [14:0]       hum_q8;
        logic [16:0]       temp_q8;
        logic [7:0]        crc;
    } reading_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        close_t     close;
        pin_t       pin;
        reading_t   typed;
    } row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        pin_t       pin;
        reading_t   typed;
    } plan_item_t;

    // Typed results; the CRC field is always predicted.
    localparam reading_t NO_READING = '0;
    // All-zero payload: temperature is -12800 in 17-bit two's complement.
    localparam reading_t ZERO_READING =
        '{htfd_pkg::STATUS_VALID, 20'h00000, 20'h00000, 15'd0, 17'h1CE00, 8'h00};
    localparam reading_t FULL_READING =
        '{htfd_pkg::STATUS_BUSY, 20'hFFFFF, 20'hFFFFF, 15'd25599, 17'd38399, 8'h00};
    localparam reading_t CRC_ERR_READING =
        '{htfd_pkg::STATUS_CRC_ERR, 20'h00000, 20'h00000, 15'd0, 17'd0, 8'h00};

    localparam int DIRECTED_COUNT = 23;
    localparam row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        // All-zero frame with a good CRC.
        '{8'h00, 1'b1, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h00, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h00, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h00, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h00, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h00, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_GOOD, PIN_ALL,    ZERO_READING},
        // All-ones frame right behind it without a frame start; the busy bit
        // wins over the bad CRC.
        '{8'hFF, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'hFF, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'hFF, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'hFF, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'hFF, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'hFF, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'hFF, 1'b0, BYTE_CRC_BAD,  PIN_ALL,    FULL_READING},
        // A partial frame abandoned by a new frame start, which then closes
        // with a bad CRC.
        '{8'h00, 1'b1, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'hAB, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h7F, 1'b1, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h12, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h34, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h56, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h78, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h9A, 1'b0, BYTE_AS_IS,    PIN_NONE,   NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_BAD,  PIN_STATUS, CRC_ERR_READING}
    };

    logic clk;
    logic rst_n;

    htfd_byte_if   byte_ch ();
    htfd_result_if result_ch ();

    humidity_temp_frame_decoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    // Decoder state as the predictor sees it.
    logic [2:0]  frame_pos = 3'd0;
    logic [7:0]  crc_run   = CRC_SEED;
    logic        busy_seen = 1'b0;
    logic [39:0] payload   = '0;

    plan_item_t byte_plan[$];
    reading_t   expected_readings[$];
    int         n_taken     = 0;
    int         error_count = 0;

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Reset is held at the start and never again.
    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // CRC-8 over one byte, MSB first, no final xor.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC of the six bytes most recently added to the plan.
    function automatic logic [7:0] frame_crc();
        logic [7:0] c;
        int         base;
        base = byte_plan.size() - 6;
        c = CRC_SEED;
        for (int k = 0; k < 6; k++)
        begin
            c = crc8_step(c, byte_plan[base + k].data);
        end
        return c;
    endfunction

    function automatic void plan_byte(input logic [7:0] data, input logic start,
                                      input pin_t pin, input reading_t typed);
        plan_item_t item;
        item.data  = data;
        item.start = start;
        item.pin   = pin;
        item.typed = typed;
        byte_plan.push_back(item);
    endfunction

    // Advances the decoder state by one word and produces the result after the last byte.
    task automatic decode_byte(input logic [7:0] b, input logic start,
                               output bit emitted, output reading_t r);
        logic [2:0]  pos;
        logic [27:0] hum_scaled;
        logic [27:0] temp_scaled;
        pos = start ? 3'd0 : frame_pos;
        emitted = 1'b0;
        r = '0;
        if (pos == 3'd0)
        begin
            crc_run   = crc8_step(CRC_SEED, b);
            busy_seen = b[7];
            payload   = '0;
            frame_pos = 3'd1;
        end
        else if (pos < FRAME_LAST)
        begin
            crc_run   = crc8_step(crc_run, b);
            payload   = {payload[31:0], b};
            frame_pos = pos + 3'd1;
        end
        else
        begin
            r.hum_raw   = payload[39:20];
            r.temp_raw  = payload[19:0];
            hum_scaled  = {8'd0, r.hum_raw} * 28'd100;
            temp_scaled = {8'd0, r.temp_raw} * 28'd200;
            r.hum_q8    = hum_scaled[26:12];
            r.temp_q8   = {1'b0, temp_scaled[27:12]} - ZERO_C_OFFSET;
            r.crc       = crc_run;
            // The busy bit takes precedence over a CRC mismatch.
            if (busy_seen)
            begin
                r.status = htfd_pkg::STATUS_BUSY;
            end
            else if (crc_run != b)
            begin
                r.status = htfd_pkg::STATUS_CRC_ERR;
            end
            else
            begin
                r.status = htfd_pkg::STATUS_VALID;
            end
            emitted   = 1'b1;
            frame_pos = 3'd0;
            crc_run   = CRC_SEED;
        end
    endtask

    task automatic compare_field(input string name, input logic [19:0] want,
                                 input logic [19:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Builds the directed frames and then the random ones.
    task automatic build_plan();
        row_t       row;
        logic [7:0] b;
        logic       st;
        bit         need_start;
        int         pick;
        int         style;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            b = row.data;
            if (row.close == BYTE_CRC_GOOD)
            begin
                b = frame_crc();
            end
            else if (row.close == BYTE_CRC_BAD)
            begin
                b = frame_crc() ^ 8'h01;
            end
            plan_byte(b, row.start, row.pin, row.typed);
        end

        // Mostly well-formed frames with random content, some cut short, some noise.
        need_start = 1'b1;
        while (byte_plan.size() < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
            begin
                st = need_start ? 1'b1 : 1'($urandom_range(0, 1));
                plan_byte({($urandom_range(0, 3) == 0), 7'($urandom)}, st, PIN_NONE, NO_READING);
                style = $urandom_range(0, 15);
                for (int k = 0; k < 5; k++)
                begin
                    b = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom);
                    plan_byte(b, 1'b0, PIN_NONE, NO_READING);
                end
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    b = frame_crc();
                end
                else if (pick < 8)
                begin
                    b = frame_crc() ^ (8'h01 << $urandom_range(0, 7));
                end
                else
                begin
                    b = 8'($urandom);
                end
                plan_byte(b, 1'b0, PIN_NONE, NO_READING);
                need_start = 1'b0;
            end
            else if (pick < 92)
            begin
                // A frame cut short; the next frame has to be marked.
                plan_byte(8'($urandom), 1'b1, PIN_NONE, NO_READING);
                repeat ($urandom_range(0, 4)) plan_byte(8'($urandom), 1'b0, PIN_NONE, NO_READING);
                need_start = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    plan_byte(8'($urandom), 1'($urandom_range(0, 1)), PIN_NONE, NO_READING);
                need_start = 1'b1;
            end
        end
    endtask

    // Byte sender: random gaps, with calm stretches that have none.
    initial
    begin : byte_sender
        int gap;
        int calm_left;
        bit calm;
        byte_ch.valid       <= 1'b0;
        byte_ch.rx_byte     <= 8'h00;
        byte_ch.frame_start <= 1'b0;
        calm_left = 0;
        calm = 1'b0;
        build_plan();
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        for (int i = 0; i < byte_plan.size(); i++)
        begin
            if (calm_left == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(10, 60);
            end
            calm_left--;
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                byte_ch.valid   <= 1'b0;
                byte_ch.rx_byte <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
            byte_ch.valid       <= 1'b1;
            byte_ch.rx_byte     <= byte_plan[i].data;
            byte_ch.frame_start <= byte_plan[i].start;
            do @(posedge clk); while (!byte_ch.ready);
        end
        byte_ch.valid <= 1'b0;
    end

    // Result receiver: random stalls, and twice a long hold-off that fills the decoder.
    initial
    begin : result_receiver
        int n_results;
        int stall;
        int calm_left;
        bit calm;
        n_results = 0;
        calm_left = 0;
        calm = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (n_results == HOLD_FIRST || n_results == HOLD_SECOND)
            begin
                stall = LONG_HOLD;
            end
            else
            begin
                if (calm_left == 0)
                begin
                    calm = ($urandom_range(0, 2) == 0);
                    calm_left = $urandom_range(5, 30);
                end
                calm_left--;
                stall = calm ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            n_results++;
        end
    end

    // Predicts on every accepted byte and checks every accepted result word.
    always @(posedge clk)
    begin : scoreboard
        bit         emitted;
        reading_t   r;
        reading_t   want;
        plan_item_t item;
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                decode_byte(byte_ch.rx_byte, byte_ch.frame_start, emitted, r);
                if (emitted)
                begin
                    item = byte_plan[n_taken];
                    if (item.pin != PIN_NONE)
                    begin
                        r.status = item.typed.status;
                    end
                    if (item.pin == PIN_ALL)
                    begin
                        r.hum_raw  = item.typed.hum_raw;
                        r.temp_raw = item.typed.temp_raw;
                        r.hum_q8   = item.typed.hum_q8;
                        r.temp_q8  = item.typed.temp_q8;
                    end
                    expected_readings.push_back(r);
                end
                n_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got status %0h",
                             $time, result_ch.result_status);
                    error_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    compare_field("result_status", 20'(want.status),
                                  20'(result_ch.result_status));
                    compare_field("humidity_raw", want.hum_raw, result_ch.humidity_raw);
                    compare_field("temperature_raw", want.temp_raw, result_ch.temperature_raw);
                    compare_field("humidity_percent_q8", 20'(want.hum_q8),
                                  20'(result_ch.humidity_percent_q8));
                    compare_field("temperature_c_q8", {3'b000, want.temp_q8},
                                  {3'b000, result_ch.temperature_c_q8});
                    compare_field("computed_crc", 20'(want.crc), 20'(result_ch.computed_crc));
                end
            end
        end
    end

    // End of run: all bytes taken, all results in, then a short tail for stray words.
    initial
    begin : end_of_run
        @(posedge clk);
        do @(posedge clk);
        while (n_taken < byte_plan.size() || expected_readings.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> humidity_temp_frame_decoder_top.f
sv/htfd_pkg.sv
sv/htfd_if.sv
sv/htfd_front.sv
sv/htfd_queue.sv
sv/htfd_back.sv
sv/humidity_temp_frame_decoder_top.sv
tb/humidity_temp_frame_decoder_top_tb.sv
